### rtl/xcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcd_pkg
// Shared types, register indexes and helper functions for the XTEA-CBC
// decryptor with a key-derived round constant.
// ----------------------------------------------------------------------------
package xcd_pkg;

  // Default round count
  localparam int ROUNDS_DEF = 32;

  // Data and register index widths
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int VB_W      = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH = 3'd5;

  // Full block, no padding removed
  localparam logic [VB_W-1:0] BYTES_FULL = 4'd8;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // good key: start decrypting the accepted item
    logic load_bad;  // zero delta: mark the accepted item as a key error
    logic round;     // run one XTEA round
    logic commit;    // write the result register and chain state
  } xcd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic delta_zero;
  } xcd_stat_t;

  // Delta gathers bits 31,27,...,3 of key words 0..3, MSB first
  function automatic logic [WORD_W-1:0] gather_delta(
    input logic [WORD_W-1:0] k0,
    input logic [WORD_W-1:0] k1,
    input logic [WORD_W-1:0] k2,
    input logic [WORD_W-1:0] k3
  );
    logic [4*WORD_W-1:0] kk;
    logic [WORD_W-1:0]   d;
    kk = {k0, k1, k2, k3};
    d  = '0;
    for (int i = 0; i < WORD_W; i++) begin
      d[WORD_W-1-i] = kk[4*WORD_W-1-4*i];
    end
    return d;
  endfunction

  // XTEA mixing function ((v << 4) ^ (v >> 5)) + v
  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // Key word select
  function automatic logic [WORD_W-1:0] key_pick(
    input logic [1:0]        sel,
    input logic [WORD_W-1:0] k0,
    input logic [WORD_W-1:0] k1,
    input logic [WORD_W-1:0] k2,
    input logic [WORD_W-1:0] k3
  );
    logic [WORD_W-1:0] k;
    case (sel)
      2'd0:    k = k0;
      2'd1:    k = k1;
      2'd2:    k = k2;
      default: k = k3;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### rtl/xcd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcd_ctrl
// Controller: takes an item, sequences the rounds, and hands the result to
// the output register when it is free.
// ----------------------------------------------------------------------------
module xcd_ctrl #(
  parameter int ROUNDS = xcd_pkg::ROUNDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire xcd_pkg::xcd_stat_t stat,
  output xcd_pkg::xcd_cmd_t      cmd
);

  localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROUNDS - 1);

  // State codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RUN    = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             in_accept;
  logic             out_free;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (stat.delta_zero) begin
            cmd.load_bad = 1'b1;
            state_next   = S_FINISH;
          end else begin
            cmd.load   = 1'b1;
            cnt_next   = CNT_LAST;
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd.round = 1'b1;
        cnt_next  = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### rtl/xcd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcd_datapath
// Datapath: configuration registers, round unit, CBC chain state and the
// result register with the padding check.
// ----------------------------------------------------------------------------
module xcd_datapath #(
  parameter int ROUNDS = xcd_pkg::ROUNDS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [xcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [xcd_pkg::WORD_W-1:0]       cfg_data,
  input  wire logic [xcd_pkg::WORD_W-1:0]       cipher_low,
  input  wire logic [xcd_pkg::WORD_W-1:0]       cipher_high,
  input  wire logic                             is_last,
  input  wire xcd_pkg::xcd_cmd_t                cmd,
  output xcd_pkg::xcd_stat_t                    stat,
  output logic [xcd_pkg::WORD_W-1:0]            plain_low,
  output logic [xcd_pkg::WORD_W-1:0]            plain_high,
  output logic [xcd_pkg::VB_W-1:0]              valid_bytes,
  output logic                                  pad_bad,
  output logic                                  key_bad
);

  localparam int W = xcd_pkg::WORD_W;
  localparam logic [W-1:0] ROUNDS_C = W'(ROUNDS);

  // Configuration and chain state
  logic [W-1:0]   key0, key1, key2, key3;
  logic [W-1:0]   iv_low, iv_high;
  logic [2*W-1:0] chain_block;
  logic           at_message_start;

  // Working registers for the item in flight
  logic [W-1:0] a, b, sum;
  logic [W-1:0] c_lo, c_hi;
  logic         last_q;
  logic         bad_q;

  logic [W-1:0] delta;
  logic [W-1:0] b_nx, sum_nx, a_nx;
  logic [W-1:0] x_lo, x_hi, p_lo, p_hi;
  logic [7:0]   pad;
  logic [xcd_pkg::VB_W-1:0] vb;
  logic         pb;

  assign delta           = xcd_pkg::gather_delta(key0, key1, key2, key3);
  assign stat.delta_zero = (delta == '0);

  // One inverse XTEA round
  assign b_nx   = b - (xcd_pkg::mix(a) ^
                  (sum + xcd_pkg::key_pick(sum[12:11], key0, key1, key2, key3)));
  assign sum_nx = sum - delta;
  assign a_nx   = a - (xcd_pkg::mix(b_nx) ^
                  (sum_nx + xcd_pkg::key_pick(sum_nx[1:0], key0, key1, key2, key3)));

  // CBC unchaining and padding check
  assign x_lo = at_message_start ? iv_low  : chain_block[W-1:0];
  assign x_hi = at_message_start ? iv_high : chain_block[2*W-1:W];
  assign p_lo = a ^ x_lo;
  assign p_hi = b ^ x_hi;
  assign pad  = p_hi[W-1:W-8];

  always_comb begin
    vb = xcd_pkg::BYTES_FULL;
    pb = 1'b0;
    if (last_q) begin
      if (pad inside {[8'd1:8'd8]}) begin
        vb = xcd_pkg::BYTES_FULL - pad[xcd_pkg::VB_W-1:0];
      end else begin
        pb = 1'b1;
      end
    end
  end

  // Configuration registers and chain state
  always_ff @(posedge clk) begin
    if (rst) begin
      key0             <= '0;
      key1             <= '0;
      key2             <= '0;
      key3             <= '0;
      iv_low           <= '0;
      iv_high          <= '0;
      chain_block      <= '0;
      at_message_start <= 1'b1;
      bad_q            <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          xcd_pkg::CFG_KEY0:    key0    <= cfg_data;
          xcd_pkg::CFG_KEY1:    key1    <= cfg_data;
          xcd_pkg::CFG_KEY2:    key2    <= cfg_data;
          xcd_pkg::CFG_KEY3:    key3    <= cfg_data;
          xcd_pkg::CFG_IV_LOW:  iv_low  <= cfg_data;
          xcd_pkg::CFG_IV_HIGH: iv_high <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        bad_q <= 1'b0;
      end else if (cmd.load_bad) begin
        bad_q <= 1'b1;
      end
      if (cmd.commit && !bad_q) begin
        chain_block      <= {c_hi, c_lo};
        at_message_start <= last_q;
      end
    end
  end

  // Round unit registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a      <= cipher_low;
      b      <= cipher_high;
      sum    <= W'(delta * ROUNDS_C);
      c_lo   <= cipher_low;
      c_hi   <= cipher_high;
      last_q <= is_last;
    end else if (cmd.round) begin
      a   <= a_nx;
      b   <= b_nx;
      sum <= sum_nx;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (bad_q) begin
        plain_low   <= '0;
        plain_high  <= '0;
        valid_bytes <= '0;
        pad_bad     <= 1'b0;
        key_bad     <= 1'b1;
      end else begin
        plain_low   <= p_lo;
        plain_high  <= p_hi;
        valid_bytes <= vb;
        pad_bad     <= pb;
        key_bad     <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/xtea_cbc_decrypt_key_delta_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_cbc_decrypt_key_delta_unit
// XTEA-CBC block decryptor whose round constant is gathered from the key.
// ----------------------------------------------------------------------------
// One 64-bit block is decrypted at a time. A block is first loaded together
// with its starting sum, then runs ROUNDS rounds on the single round unit
// (one full XTEA round per cycle), and is then unchained, padding-checked
// and written to the output register once that register is free. A block
// whose key gives a zero delta skips the rounds and returns key_bad with all
// other fields zero. in_ready is high only while the round unit is free; a
// finished result waits in the output register, so the next block can be
// taken before it is collected. The configuration port is always ready;
// write it only while no block is in flight. Register indexes: 0..3 key
// words, 4 IV low, 5 IV high.
// ----------------------------------------------------------------------------
module xtea_cbc_decrypt_key_delta_unit #(
  parameter int ROUNDS = xcd_pkg::ROUNDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [xcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [xcd_pkg::WORD_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [xcd_pkg::WORD_W-1:0]    cipher_low,
  input  wire logic [xcd_pkg::WORD_W-1:0]    cipher_high,
  input  wire logic                          is_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [xcd_pkg::WORD_W-1:0]         plain_low,
  output logic [xcd_pkg::WORD_W-1:0]         plain_high,
  output logic [xcd_pkg::VB_W-1:0]           valid_bytes,
  output logic                               pad_bad,
  output logic                               key_bad
);

  xcd_pkg::xcd_cmd_t  cmd;
  xcd_pkg::xcd_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer
  xcd_ctrl #(
    .ROUNDS (ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Round unit and state
  xcd_datapath #(
    .ROUNDS (ROUNDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cipher_low  (cipher_low),
    .cipher_high (cipher_high),
    .is_last     (is_last),
    .cmd         (cmd),
    .stat        (stat),
    .plain_low   (plain_low),
    .plain_high  (plain_high),
    .valid_bytes (valid_bytes),
    .pad_bad     (pad_bad),
    .key_bad     (key_bad)
  );

  // One block at a time: the unit is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high in the cycle after an item was taken");

  // A key error carries no plaintext
  a_key_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_bad) |->
      (plain_low == '0 && plain_high == '0 && valid_bytes == '0 && !pad_bad))
    else $error("key error result carries data");

  // Byte count stays within one block
  a_vb_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_bytes <= xcd_pkg::BYTES_FULL))
    else $error("valid_bytes above eight");

  // Bad padding keeps the whole block
  a_pad_bad_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pad_bad) |-> (valid_bytes == xcd_pkg::BYTES_FULL && !key_bad))
    else $error("pad_bad with a short block or a key error");

endmodule
`default_nettype wire
